// ----- sv/bvs_pkg.sv -----
`timescale 1ns / 1ps

package bvs_pkg;

  // Byte codes of the bencode grammar
  localparam logic [7:0] ChE     = 8'h65;  // 'e'
  localparam logic [7:0] ChD     = 8'h64;  // 'd'
  localparam logic [7:0] ChL     = 8'h6c;  // 'l'
  localparam logic [7:0] ChI     = 8'h69;  // 'i'
  localparam logic [7:0] ChColon = 8'h3a;  // ':'
  localparam logic [7:0] Ch0     = 8'h30;  // '0'
  localparam logic [7:0] Ch9     = 8'h39;  // '9'

  // Field widths
  localparam int unsigned DepthCfgW = 5;
  localparam int unsigned LengthW   = 16;
  localparam int unsigned StatusW   = 2;

  // Result status codes
  typedef enum logic [StatusW-1:0] {
    ST_BUSY  = 2'd0,
    ST_DONE  = 2'd1,
    ST_ERROR = 2'd2,
    ST_DROP  = 2'd3
  } status_e;

  // Kind of an open list or dictionary frame
  typedef enum logic [1:0] {
    KIND_LIST = 2'd0,
    KIND_KEY  = 2'd1,
    KIND_VAL  = 2'd2
  } kind_e;

  // Parser phase, one-hot
  typedef enum logic [4:0] {
    PH_START   = 5'b00001,
    PH_INT     = 5'b00010,
    PH_LEN     = 5'b00100,
    PH_DATA    = 5'b01000,
    PH_DISCARD = 5'b10000
  } phase_e;

  // Command from the parser to the frame stack
  typedef struct packed {
    logic  accept;     // a word is consumed this cycle
    logic  push;       // open a new frame
    logic  pop;        // close the top frame
    kind_e keep_kind;  // updated kind of the current top
    kind_e new_kind;   // kind of the frame being opened
  } stack_cmd_t;

endpackage

// ----- sv/bvs_frame_stack.sv -----
`timescale 1ns / 1ps

module bvs_frame_stack #(
  parameter int unsigned STACK_DEPTH = 32
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  bvs_pkg::stack_cmd_t             cmd_i,
  input  logic [$clog2(STACK_DEPTH)-1:0]  depth_i,
  output bvs_pkg::kind_e                  top_o
);
  import bvs_pkg::*;

  localparam int unsigned DW = $clog2(STACK_DEPTH);

  // Frames below the top; the top frame itself lives in top_q
  kind_e            mem [STACK_DEPTH];
  kind_e            top_q, top_d;
  kind_e            rd_q;
  kind_e            fwd_kind_q;
  logic             fwd_q;
  logic  [DW-1:0]   rd_addr;
  kind_e            below;

  // Frame under the top: forward a push that wrote it on the previous accepted word
  assign below = fwd_q ? fwd_kind_q : rd_q;
  assign top_o = top_q;

  // Prefetch the frame below the next top
  always_comb begin
    if (cmd_i.push) begin
      rd_addr = depth_i;
    end else if (cmd_i.pop) begin
      rd_addr = depth_i - DW'(2);
    end else begin
      rd_addr = depth_i - DW'(1);
    end
  end

  // Select the next top frame
  always_comb begin
    if (cmd_i.push) begin
      top_d = cmd_i.new_kind;
    end else if (cmd_i.pop) begin
      top_d = below;
    end else begin
      top_d = cmd_i.keep_kind;
    end
  end

  // Memory: spill the old top on push, read one entry per word
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      if (cmd_i.push) begin
        mem[depth_i] <= cmd_i.keep_kind;
      end
      rd_q       <= mem[rd_addr];
      fwd_kind_q <= cmd_i.keep_kind;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      top_q <= KIND_LIST;
      fwd_q <= 1'b0;
    end else if (cmd_i.accept) begin
      top_q <= top_d;
      fwd_q <= cmd_i.push;
    end
  end

endmodule

// ----- sv/bencode_value_skipper.sv -----
`timescale 1ns / 1ps

// Channel   Direction  Words                         Handshake
// s_axis    in         tdata=data_byte, tlast=is_last tvalid/tready
// m_axis    out        tdata=value_length, tuser=status tvalid/tready
// cfg       in         cfg_data_i=max_depth           cfg_valid_i/cfg_ready_o
//
// One word per cycle unless stalled; each word yields one registered result.
// Frame kinds sit in a one-read one-write synchronous memory; the frame below
// the top is prefetched each word, with a bypass when a push wrote it on the
// word accepted before.
// Reset is asynchronous active low and clears phase, depth and counters; the
// stack memory needs no clearing pass. A two-entry output buffer keeps taking
// words while the sink stalls; s_axis_tready drops only when both are full.

module bencode_value_skipper #(
  parameter int unsigned      STACK_DEPTH = 32,
  parameter longint unsigned  MAX_BYTES   = 65535
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tlast,   // is_last
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [15:0] value_length
  output logic [1:0]  m_axis_tuser,   // [1:0] status
  // configuration
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [4:0]  cfg_data_i      // max_depth
);
  import bvs_pkg::*;

  localparam int unsigned DW  = $clog2(STACK_DEPTH);
  localparam int unsigned CW  = $clog2(MAX_BYTES + 64'd1);
  localparam logic [6:0]  Lim = 7'(STACK_DEPTH - 1);

  typedef struct packed {
    status_e              status;
    logic [LengthW-1:0]   length;
  } result_t;

  // State
  phase_e                 phase_q, phase_d;
  logic [DW-1:0]          depth_q, depth_d;
  logic [CW-1:0]          sr_q, sr_d;
  logic [CW-1:0]          bytes_q, bytes_d;
  logic [DepthCfgW-1:0]   max_depth_q;
  kind_e                  top;
  stack_cmd_t             cmd;

  // Output buffer
  logic                   out_valid_q, skid_valid_q;
  result_t                out_q, skid_q, res;

  logic                   accept;
  logic [7:0]             b;
  logic [3:0]             digit;
  logic                   is_digit;
  logic [CW:0]            count;
  logic [CW+3:0]          sr_mul;
  logic [CW-1:0]          sr_dec;
  logic [6:0]             limit;
  logic                   err, item_done, done;

  assign accept        = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = !skid_valid_q;
  assign cfg_ready_o   = 1'b1;
  assign b             = s_axis_tdata;
  assign digit         = 4'(b - Ch0);
  assign is_digit      = (b >= Ch0) && (b <= Ch9);
  assign count         = (CW+1)'(bytes_q) + (CW+1)'(1);
  assign sr_mul        = ((CW+4)'(sr_q) << 3) + ((CW+4)'(sr_q) << 1) + (CW+4)'(digit);
  assign sr_dec        = (sr_q != '0) ? sr_q - CW'(1) : '0;
  assign limit         = (7'(max_depth_q) > Lim) ? Lim : 7'(max_depth_q);

  // Parse one byte
  always_comb begin
    phase_d       = phase_q;
    depth_d       = depth_q;
    sr_d          = sr_q;
    bytes_d       = bytes_q;
    res.status    = ST_BUSY;
    res.length    = '0;
    err           = 1'b0;
    item_done     = 1'b0;
    done          = 1'b0;
    cmd.accept    = accept;
    cmd.push      = 1'b0;
    cmd.pop       = 1'b0;
    cmd.keep_kind = top;
    cmd.new_kind  = (b == ChD) ? KIND_KEY : KIND_LIST;

    if (phase_q == PH_DISCARD) begin
      res.status = ST_DROP;
      if (s_axis_tlast) begin
        phase_d = PH_START;
        depth_d = '0;
        sr_d    = '0;
        bytes_d = '0;
      end
    end else begin
      if (64'(count) > MAX_BYTES) begin
        err = 1'b1;
      end else begin
        case (phase_q)
          PH_START: begin
            // advance the dictionary key/value alternation
            if (depth_q != '0) begin
              if (top == KIND_KEY && b != ChE) begin
                cmd.keep_kind = KIND_VAL;
              end else if (top == KIND_VAL) begin
                if (b == ChE) begin
                  err = 1'b1;
                end
                cmd.keep_kind = KIND_KEY;
              end
            end
            if (!err) begin
              if (b == ChE) begin
                if (depth_q == '0) begin
                  err = 1'b1;
                end else begin
                  cmd.pop = 1'b1;
                  depth_d = depth_q - DW'(1);
                  if (depth_q == DW'(1)) begin
                    done = 1'b1;
                  end
                end
              end else if (b == ChD || b == ChL) begin
                if (7'(depth_q) >= limit) begin
                  err = 1'b1;
                end else begin
                  cmd.push = 1'b1;
                  depth_d  = depth_q + DW'(1);
                end
              end else if (b == ChI) begin
                phase_d = PH_INT;
              end else if (is_digit) begin
                sr_d    = CW'(digit);
                phase_d = PH_LEN;
              end else begin
                err = 1'b1;
              end
            end
          end
          PH_INT: begin
            if (b == ChE) begin
              item_done = 1'b1;
            end
          end
          PH_LEN: begin
            if (is_digit) begin
              sr_d = sr_mul[CW-1:0];
              if (64'(sr_mul) > MAX_BYTES) begin
                err = 1'b1;
              end
            end else if (b == ChColon) begin
              if (sr_q == '0) begin
                item_done = 1'b1;
              end else begin
                phase_d = PH_DATA;
              end
            end else begin
              err = 1'b1;
            end
          end
          PH_DATA: begin
            sr_d = sr_dec;
            if (sr_dec == '0) begin
              item_done = 1'b1;
            end
          end
          default: begin
            err = 1'b1;
          end
        endcase
      end

      if (!err && item_done) begin
        phase_d = PH_START;
        sr_d    = '0;
        if (depth_q == '0) begin
          done = 1'b1;
        end
      end

      if (!err && done) begin
        res.status = ST_DONE;
        res.length = LengthW'(count);
        phase_d    = PH_START;
        depth_d    = '0;
        sr_d       = '0;
        bytes_d    = '0;
      end else if (err || s_axis_tlast) begin
        res.status = ST_ERROR;
        phase_d    = s_axis_tlast ? PH_START : PH_DISCARD;
        depth_d    = '0;
        sr_d       = '0;
        bytes_d    = '0;
      end else begin
        bytes_d = count[CW-1:0];
      end
    end
  end

  bvs_frame_stack #(
    .STACK_DEPTH(STACK_DEPTH)
  ) u_stack (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (cmd),
    .depth_i (depth_q),
    .top_o   (top)
  );

  // Hold parser state; advance on each accepted word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_START;
      depth_q     <= '0;
      sr_q        <= '0;
      bytes_q     <= '0;
      max_depth_q <= 5'd31;
    end else begin
      if (accept) begin
        phase_q <= phase_d;
        depth_q <= depth_d;
        sr_q    <= sr_d;
        bytes_q <= bytes_d;
      end
      if (cfg_valid_i) begin
        max_depth_q <= cfg_data_i;
      end
    end
  end

  // Output register plus skid entry
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (!out_valid_q || m_axis_tready) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= accept;
      end else begin
        out_valid_q  <= accept;
      end
    end else if (accept) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_valid_q || m_axis_tready) begin
      if (skid_valid_q) begin
        out_q <= skid_q;
        if (accept) begin
          skid_q <= res;
        end
      end else if (accept) begin
        out_q <= res;
      end
    end else if (accept) begin
      skid_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q.length;
  assign m_axis_tuser  = out_q.status;

endmodule

// ----- sv/bvs_checker.sv -----
`timescale 1ns / 1ps

module bvs_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata,
  input logic [1:0]  m_axis_tuser
);
  import bvs_pkg::*;

  // An empty output side never throttles the input
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled while output is empty");

  // A word taken into an empty block shows up on the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && !m_axis_tvalid) |=> m_axis_tvalid)
    else $error("result missing one cycle after input word");

  // Length is zero except on a completed value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser != ST_DONE) |-> (m_axis_tdata == 16'd0))
    else $error("length set on a result that is not complete");

  // A stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
    else $error("stalled result changed");

endmodule

bind bencode_value_skipper bvs_checker u_bvs_checker (.*);

// ----- tb/bvs_extent_checker.sv -----
`timescale 1ns / 1ps

module bvs_extent_checker
  import bvs_pkg::*;
#(
  parameter int unsigned StackDepth = 32,
  parameter int unsigned MaxBytes   = 65535
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  input  logic                 s_axis_tready,
  input  logic [7:0]           s_axis_tdata,   // [7:0] data_byte
  input  logic                 s_axis_tlast,   // is_last
  input  logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  input  logic [LengthW-1:0]   m_axis_tdata,   // [15:0] value_length
  input  logic [StatusW-1:0]   m_axis_tuser,   // [1:0] status
  input  logic                 cfg_valid_i,
  input  logic                 cfg_ready_o,
  input  logic [DepthCfgW-1:0] cfg_data_i,     // max_depth
  output int                   fail_count_o,
  output int                   pending_o
);

  localparam logic [DepthCfgW-1:0] DepthReset = 5'd31;

  typedef struct packed {
    status_e             status;
    logic [LengthW-1:0]  length;
  } extent_t;

  // Shadow of the parser
  logic [DepthCfgW-1:0] depth_cap_q;
  phase_e               phase_q;
  int unsigned          nest_q;
  kind_e                frames_q [StackDepth];
  int unsigned          str_left_q;
  int unsigned          taken_q;

  extent_t extents_q[$];
  int      mismatches;

  // Drop the value in progress and wait for a new one
  task automatic clear_value();
    phase_q    = PH_START;
    nest_q     = 0;
    str_left_q = 0;
    taken_q    = 0;
  endtask

  task automatic flag(input string what);
    mismatches++;
    if (mismatches <= 10) $display("[%0t] mismatch: %s", $time, what);
  endtask

  // Advance the shadow parser by one word and queue the status it must give
  task automatic predict_extent(input logic [7:0] b, input logic last);
    extent_t     r;
    logic        err;
    logic        item_done;
    logic        done;
    int unsigned count;
    int unsigned lim;
    err       = 1'b0;
    item_done = 1'b0;
    done      = 1'b0;
    r.status  = ST_BUSY;
    r.length  = '0;
    count     = taken_q + 1;
    lim       = (depth_cap_q > StackDepth - 1) ? StackDepth - 1 : depth_cap_q;
    if (phase_q == PH_DISCARD) begin
      r.status = ST_DROP;
      if (last) clear_value();
    end else begin
      if (count > MaxBytes) begin
        err = 1'b1;
      end else begin
        case (phase_q)
          PH_START: begin
            // Toggle the key/value slot of an open dictionary
            if (nest_q > 0) begin
              if (frames_q[nest_q] == KIND_KEY) begin
                if (b != ChE) frames_q[nest_q] = KIND_VAL;
              end else if (frames_q[nest_q] == KIND_VAL) begin
                if (b == ChE) err = 1'b1;
                frames_q[nest_q] = KIND_KEY;
              end
            end
            if (!err) begin
              if (b == ChE) begin
                if (nest_q == 0) begin
                  err = 1'b1;
                end else begin
                  nest_q--;
                  if (nest_q == 0) done = 1'b1;
                end
              end else if (b == ChD || b == ChL) begin
                if (nest_q >= lim) begin
                  err = 1'b1;
                end else begin
                  nest_q++;
                  frames_q[nest_q] = (b == ChD) ? KIND_KEY : KIND_LIST;
                end
              end else if (b == ChI) begin
                phase_q = PH_INT;
              end else if (b >= Ch0 && b <= Ch9) begin
                str_left_q = b - Ch0;
                phase_q    = PH_LEN;
              end else begin
                err = 1'b1;
              end
            end
          end
          PH_INT: begin
            if (b == ChE) item_done = 1'b1;
          end
          PH_LEN: begin
            if (b >= Ch0 && b <= Ch9) begin
              str_left_q = str_left_q * 10 + (b - Ch0);
              if (str_left_q > MaxBytes) err = 1'b1;
            end else if (b == ChColon) begin
              if (str_left_q == 0) item_done = 1'b1;
              else phase_q = PH_DATA;
            end else begin
              err = 1'b1;
            end
          end
          default: begin
            if (str_left_q > 0) str_left_q--;
            if (str_left_q == 0) item_done = 1'b1;
          end
        endcase
      end
      if (!err && item_done) begin
        phase_q    = PH_START;
        str_left_q = 0;
        if (nest_q == 0) done = 1'b1;
      end
      if (!err && done) begin
        r.status = ST_DONE;
        r.length = count[LengthW-1:0];
        clear_value();
      end else begin
        if (last) err = 1'b1;
        if (err) begin
          r.status = ST_ERROR;
          clear_value();
          if (!last) phase_q = PH_DISCARD;
        end else begin
          taken_q = count;
        end
      end
    end
    extents_q.push_back(r);
  endtask

  // Compare results first: a word never leaves in the cycle it is taken
  always @(posedge clk_i or negedge rst_ni) begin
    extent_t want;
    if (!rst_ni) begin
      depth_cap_q = DepthReset;
      clear_value();
      foreach (frames_q[k]) frames_q[k] = KIND_LIST;
      extents_q.delete();
      mismatches = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (extents_q.size() == 0) begin
          flag($sformatf("unexpected result word, status %0d length %0d",
                         m_axis_tuser, m_axis_tdata));
        end else begin
          want = extents_q.pop_front();
          if (m_axis_tuser !== want.status)
            flag($sformatf("status expected %0d, got %0d", want.status, m_axis_tuser));
          if (m_axis_tdata !== want.length)
            flag($sformatf("value_length expected %0d, got %0d",
                           want.length, m_axis_tdata));
        end
      end
      if (cfg_valid_i && cfg_ready_o) depth_cap_q = cfg_data_i;
      if (s_axis_tvalid && s_axis_tready) predict_extent(s_axis_tdata, s_axis_tlast);
    end
    pending_o    <= extents_q.size();
    fail_count_o <= mismatches;
  end

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
  import bvs_pkg::*;

  localparam int unsigned StackDepth  = 32;
  localparam int unsigned MaxBytes    = 65535;
  localparam int unsigned HalfPeriod  = 5;
  localparam int unsigned ResetCycles = 7;
  localparam int unsigned SinkHold    = 400;
  localparam int unsigned IdleLimit   = 3000;

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [7:0]           s_axis_tdata  = '0;
  logic                 s_axis_tlast  = 1'b0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [LengthW-1:0]   m_axis_tdata;
  logic [StatusW-1:0]   m_axis_tuser;
  logic                 cfg_valid_i   = 1'b0;
  logic                 cfg_ready_o;
  logic [DepthCfgW-1:0] cfg_data_i    = '0;

  int fail_count;
  int pending;
  int idle_cycles = 0;

  // hold_sink is shared with the sink process; the rest is stimulus state
  bit                   hold_sink = 1'b0;
  logic [DepthCfgW-1:0] depth_cap = 5'd31;
  logic [7:0]           text_q[$];

  always #HalfPeriod clk_i = ~clk_i;

  bencode_value_skipper #(
    .STACK_DEPTH(StackDepth),
    .MAX_BYTES  (MaxBytes)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i)
  );

  bvs_extent_checker #(
    .StackDepth(StackDepth),
    .MaxBytes  (MaxBytes)
  ) i_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // Gap length: mostly short, a few long
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Append one random bencode value; lvl is the nesting already open
  function automatic void add_value(input int unsigned lvl, input int unsigned room);
    int unsigned pick;
    int unsigned n;
    int unsigned k;
    logic [7:0]  b;
    string       digits;
    pick = (lvl < room) ? $urandom_range(0, 3) : $urandom_range(0, 1);
    case (pick)
      0: begin
        text_q.push_back(ChI);
        n = $urandom_range(0, 4);
        repeat (n) begin
          do b = 8'($urandom_range(0, 255)); while (b == ChE);
          text_q.push_back(b);
        end
        text_q.push_back(ChE);
      end
      1: begin
        n = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 9);
        if ($urandom_range(0, 9) == 0) text_q.push_back(Ch0);
        digits = $sformatf("%0d", n);
        for (k = 0; k < digits.len(); k++) text_q.push_back(digits[k]);
        text_q.push_back(ChColon);
        repeat (n) begin
          b = 8'($urandom_range(0, 255));
          text_q.push_back(b);
        end
      end
      2: begin
        text_q.push_back(ChL);
        n = $urandom_range(0, 3);
        repeat (n) add_value(lvl + 1, room);
        text_q.push_back(ChE);
      end
      default: begin
        text_q.push_back(ChD);
        n = $urandom_range(0, 2);
        repeat (n) begin
          add_value(lvl + 1, room);
          add_value(lvl + 1, room);
        end
        // dangling key, closed where a value belongs
        if ($urandom_range(0, 9) == 0) add_value(lvl + 1, room);
        text_q.push_back(ChE);
      end
    endcase
  endfunction

  // Build one buffer: mostly well-formed values, some damaged, some noise
  function automatic void make_buffer();
    int unsigned r;
    int unsigned n;
    int unsigned k;
    int unsigned room;
    logic [7:0]  b;
    text_q.delete();
    room = (depth_cap < 3) ? depth_cap : 3;
    r = $urandom_range(0, 99);
    if (r < 4) begin
      // nest right up to the limit, sometimes one past it
      n = depth_cap + $urandom_range(0, 1);
      repeat (n) text_q.push_back(ChL);
      repeat (n) text_q.push_back(ChE);
    end else if (r < 10) begin
      // raw noise or a bare run of length digits
      n = $urandom_range(1, 7);
      repeat (n) begin
        b = (r < 7) ? 8'($urandom_range(0, 255)) : Ch0 + 8'($urandom_range(0, 9));
        text_q.push_back(b);
      end
    end else begin
      n = $urandom_range(1, 3);
      repeat (n) add_value(0, room);
      r = $urandom_range(0, 99);
      if (r < 8 && text_q.size() > 1) begin
        k = $urandom_range(1, text_q.size() - 1);
        while (text_q.size() > k) void'(text_q.pop_back());
      end else if (r < 16) begin
        b = 8'($urandom_range(0, 255));
        text_q[$urandom_range(0, text_q.size() - 1)] = b;
      end else if (r < 22) begin
        text_q.insert($urandom_range(0, text_q.size()), ChE);
      end
    end
  endfunction

  // Offer one word and hold it until taken
  task automatic send_word(input logic [7:0] b, input logic last, input bit eager);
    int unsigned gap;
    gap = (eager || $urandom_range(0, 99) < 55) ? 0 : pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic send_buffer(input bit eager);
    int unsigned k;
    for (k = 0; k < text_q.size(); k++)
      send_word(text_q[k], k == text_q.size() - 1, eager);
  endtask

  task automatic send_text(input string s);
    int unsigned k;
    text_q.delete();
    for (k = 0; k < s.len(); k++) text_q.push_back(s[k]);
    send_buffer(1'b0);
  endtask

  // String of n random bytes, sent back to back
  task automatic send_long_string(input int unsigned n);
    string       digits;
    int unsigned k;
    logic [7:0]  b;
    digits = $sformatf("%0d", n);
    for (k = 0; k < digits.len(); k++) send_word(digits[k], 1'b0, 1'b1);
    send_word(ChColon, 1'b0, 1'b1);
    for (k = 1; k <= n; k++) begin
      b = 8'($urandom_range(0, 255));
      send_word(b, k == n, 1'b1);
    end
  endtask

  // Hold until every result has come back
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  task automatic write_depth(input logic [DepthCfgW-1:0] v);
    wait_drained();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    depth_cap = v;
  endtask

  task automatic random_phase(input int unsigned target);
    int unsigned sent;
    sent = 0;
    while (sent < target) begin
      make_buffer();
      send_buffer($urandom_range(0, 3) == 0);
      sent += text_q.size();
    end
  endtask

  // Sink: stretches with and without stalls, plus a long hold on request
  initial begin : sink
    int unsigned stall;
    int unsigned calm_left;
    bit          calm;
    stall     = 0;
    calm_left = 0;
    calm      = 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (hold_sink) begin
        m_axis_tready <= 1'b0;
        repeat (SinkHold) @(posedge clk_i);
        hold_sink = 1'b0;
      end else begin
        if (calm_left == 0) begin
          calm      = ($urandom_range(0, 3) == 0);
          calm_left = $urandom_range(20, 200);
        end
        calm_left--;
        if (stall > 0) begin
          stall--;
          m_axis_tready <= 1'b0;
        end else if (!calm && $urandom_range(0, 4) == 0) begin
          stall = pick_gap() - 1;
          m_axis_tready <= 1'b0;
        end else begin
          m_axis_tready <= 1'b1;
        end
        @(posedge clk_i);
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
        || (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("Some tests failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed words at the reset depth limit
    send_text("i0e");
    send_text("0:");
    send_text("di1ei2ee");
    send_text("e");
    send_text("d1:aex");
    send_text("#5");
    send_text("l");
    send_text("999999");
    send_text("65536x");
    text_q = {8'h33, ChColon, 8'h00, 8'hff, 8'h80};
    send_buffer(1'b0);
    text_q.delete();
    repeat (31) text_q.push_back(ChL);
    repeat (31) text_q.push_back(ChE);
    send_buffer(1'b0);
    text_q.delete();
    repeat (32) text_q.push_back(ChL);
    text_q.push_back(ChE);
    send_buffer(1'b0);

    // Long string sent back to back
    send_long_string(250);

    random_phase(300);

    // Shallowest limit
    write_depth(5'd1);
    send_text("lle");
    send_text("l1:ae");
    send_text("de");
    random_phase(250);

    // Deepest limit, with the sink held off while words keep coming
    write_depth(5'd31);
    hold_sink = 1'b1;
    random_phase(250);

    write_depth(DepthCfgW'($urandom_range(2, 30)));
    random_phase(250);
    write_depth(DepthCfgW'($urandom_range(2, 30)));
    random_phase(250);

    wait_drained();
    repeat (4) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
